// ===== src/cffm_pkg.sv =====
// ----------------------------------------------------------------------------
// cffm_pkg
// Shared types and codes of the CAN frame fault monitor: request and result
// payloads, operation and result codes, register indexes and limits.
// ----------------------------------------------------------------------------
`default_nettype none

package cffm_pkg;

  localparam int SLOT_CAP = 3;
  localparam logic [1:0] NO_SLOT = 2'd3;

  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_TX    = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    RC_OK          = 3'd0,
    RC_UNKNOWN     = 3'd1,
    RC_MUTED       = 3'd2,
    RC_CRC         = 3'd3,
    RC_CREDIBILITY = 3'd4,
    RC_SYNC        = 3'd5
  } result_code_t;

  localparam logic [2:0] CFG_SLAVE_ID_ZERO    = 3'd0;
  localparam logic [2:0] CFG_SLAVE_ID_ONE     = 3'd1;
  localparam logic [2:0] CFG_SLAVE_ID_TWO     = 3'd2;
  localparam logic [2:0] CFG_CRC_ERROR_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_FRAME_LOSS_LIMIT = 3'd4;
  localparam logic [2:0] CFG_CREDIBLE_MAX     = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [28:0] can_id;
    logic [7:0]  seq_in;
    logic [15:0] payload;
    logic        crc_ok;
  } frame_t;

  typedef struct packed {
    logic [2:0]  result_code;
    logic [1:0]  slave_slot;
    logic [7:0]  tx_seq;
    logic [15:0] held_data;
    logic [15:0] crc_error_total;
  } result_t;

  typedef struct packed {
    logic [7:0]  crc_error_limit;
    logic [7:0]  frame_loss_limit;
    logic [15:0] credible_max;
  } limits_t;

endpackage

`default_nettype wire

// ===== src/cffm_ram.sv =====
// ----------------------------------------------------------------------------
// cffm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cffm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/cffm_ctx_update.sv =====
// ----------------------------------------------------------------------------
// cffm_ctx_update
// Frame check and context update for one slot: mute, CRC, credibility and
// sequence checks, transmit sequence assignment, and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module cffm_ctx_update #(
  parameter int SEQ_BITS  = 8,
  parameter int DATA_BITS = 16
) (
  input  wire logic [1:0]           op,
  input  wire logic [1:0]           slot,
  input  wire logic [7:0]           seq_in,
  input  wire logic [15:0]          payload,
  input  wire logic                 crc_ok,
  input  wire cffm_pkg::limits_t    limits,
  input  wire logic [SEQ_BITS-1:0]  exp_seq,
  input  wire logic [15:0]          fail_count,
  input  wire logic [7:0]           fail_run,
  input  wire logic [7:0]           lost,
  input  wire logic                 muted,
  input  wire logic [DATA_BITS-1:0] good_data,
  output logic                      ctx_wr,
  output logic      [SEQ_BITS-1:0]  exp_seq_next,
  output logic      [15:0]          fail_count_next,
  output logic      [7:0]           fail_run_next,
  output logic      [7:0]           lost_next,
  output logic                      muted_next,
  output logic      [DATA_BITS-1:0] good_data_next,
  output cffm_pkg::result_t         result
);

  import cffm_pkg::*;

  logic [SEQ_BITS+7:0]   seq_ext;
  logic [SEQ_BITS-1:0]   seq_w;
  logic [DATA_BITS+15:0] data_ext;
  logic [DATA_BITS-1:0]  data_w;
  logic [DATA_BITS+15:0] max_ext;
  logic [DATA_BITS+15:0] data_cmp;
  logic [SEQ_BITS+7:0]   tx_ext;
  logic [DATA_BITS+15:0] held_ext;
  logic [SEQ_BITS-1:0]   tx;
  logic                  slot_hit;

  always_comb begin
    seq_ext  = {{SEQ_BITS{1'b0}}, seq_in};
    seq_w    = seq_ext[SEQ_BITS-1:0];
    data_ext = {{DATA_BITS{1'b0}}, payload};
    data_w   = data_ext[DATA_BITS-1:0];
    data_cmp = {16'd0, data_w};
    max_ext  = {{DATA_BITS{1'b0}}, limits.credible_max};
    slot_hit = (slot != NO_SLOT);

    exp_seq_next    = exp_seq;
    fail_count_next = fail_count;
    fail_run_next   = fail_run;
    lost_next       = lost;
    muted_next      = muted;
    good_data_next  = good_data;
    tx              = '0;
    ctx_wr          = 1'b0;
    result.result_code = RC_OK;

    if (op == OP_CHECK || op == OP_TX) begin
      if (!slot_hit) begin
        result.result_code = RC_UNKNOWN;
      end else if (op == OP_TX) begin
        ctx_wr       = 1'b1;
        tx           = exp_seq;
        exp_seq_next = exp_seq + SEQ_BITS'(1);
      end else if (muted) begin
        result.result_code = RC_MUTED;
      end else if (!crc_ok) begin
        ctx_wr = 1'b1;
        if (fail_count != 16'hFFFF) begin
          fail_count_next = fail_count + 16'd1;
        end
        if (fail_run != 8'hFF) begin
          fail_run_next = fail_run + 8'd1;
        end
        if (fail_run_next >= limits.crc_error_limit) begin
          muted_next   = 1'b1;
          lost_next    = 8'd0;
          exp_seq_next = '0;
        end
        result.result_code = RC_CRC;
      end else begin
        ctx_wr        = 1'b1;
        fail_run_next = 8'd0;
        if (data_cmp > max_ext) begin
          result.result_code = RC_CREDIBILITY;
        end else if (seq_w != exp_seq) begin
          if (lost != 8'hFF) begin
            lost_next = lost + 8'd1;
          end
          exp_seq_next = seq_w + SEQ_BITS'(1);
          if (lost_next >= limits.frame_loss_limit) begin
            lost_next    = 8'd0;
            exp_seq_next = '0;
          end
          result.result_code = RC_SYNC;
        end else begin
          exp_seq_next   = exp_seq + SEQ_BITS'(1);
          good_data_next = data_w;
        end
      end
    end

    tx_ext   = {8'd0, tx};
    held_ext = {16'd0, good_data_next};
    result.slave_slot      = (op == OP_CHECK || op == OP_TX) ? slot : NO_SLOT;
    result.tx_seq          = tx_ext[7:0];
    result.held_data       = (slot_hit && (op == OP_CHECK || op == OP_TX)) ?
                             held_ext[15:0] : 16'd0;
    result.crc_error_total = (slot_hit && (op == OP_CHECK || op == OP_TX)) ?
                             fail_count_next : 16'd0;
  end

endmodule

`default_nettype wire

// ===== src/can_frame_fault_monitor.sv =====
// ----------------------------------------------------------------------------
// can_frame_fault_monitor
// End-to-end checker for CAN frames with one fault context per sender slot.
// ----------------------------------------------------------------------------
// Requests enter on frame_valid/frame_ready and carry an operation: check a
// received frame, assign a transmit sequence number, or clear all contexts.
// Every request gives exactly one result on result_valid/result_ready.
// Registers are written on cfg_valid/cfg_ready (always ready); the user must
// write them only while idle, the block itself does not enforce it. The slot
// lookup and context RAM read fill the check stage, then the update, write
// back and result register follow. While the receiver takes results, one
// request per cycle is sustained, also back to back to one slot (forwarded).
// The per slot contexts sit in a RAM of NUM_SLAVES entries; one valid flop
// per entry, cleared by reset and by the clear operation, makes an unwritten
// entry read as zero, so there is no clearing pass.
// Reset restores the register defaults and empties the pipeline.
// When the receiver stalls, the result register holds its request, the
// check stage waits behind it and frame_ready drops once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module can_frame_fault_monitor #(
  parameter int NUM_SLAVES = 3,
  parameter int SEQ_BITS   = 8,
  parameter int DATA_BITS  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              frame_valid,
  output logic                   frame_ready,
  input  wire cffm_pkg::frame_t  frame,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output cffm_pkg::result_t      result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [28:0]       cfg_data
);

  import cffm_pkg::*;

  localparam int AW    = (NUM_SLAVES > 1) ? $clog2(NUM_SLAVES) : 1;
  localparam int CTX_W = SEQ_BITS + 16 + 8 + 8 + 1 + DATA_BITS;

  logic [28:0] slave_id [SLOT_CAP];
  limits_t     limits;

  logic [1:0]  lookup_slot;
  logic        lookup_hit;
  logic        frame_fire;

  logic        s1_valid;
  logic        s1_go;
  logic        s1_fire;
  logic [1:0]  s1_op;
  logic [1:0]  s1_slot;
  logic [7:0]  s1_seq;
  logic [15:0] s1_payload;
  logic        s1_crc_ok;

  logic [NUM_SLAVES-1:0] ctx_valid;
  logic                  fwd_valid;
  logic [1:0]            fwd_slot;
  logic [CTX_W-1:0]      fwd_ctx;
  logic                  fwd_hit;

  logic [CTX_W-1:0] ram_q;
  logic [CTX_W-1:0] ctx_cur;
  logic [CTX_W-1:0] ctx_new;
  logic [AW-1:0]    ram_raddr;

  logic [SEQ_BITS-1:0]  exp_seq;
  logic [15:0]          fail_count;
  logic [7:0]           fail_run;
  logic [7:0]           lost;
  logic                 muted;
  logic [DATA_BITS-1:0] good_data;
  logic [SEQ_BITS-1:0]  exp_seq_next;
  logic [15:0]          fail_count_next;
  logic [7:0]           fail_run_next;
  logic [7:0]           lost_next;
  logic                 muted_next;
  logic [DATA_BITS-1:0] good_data_next;
  logic                 ctx_wr;
  logic                 ram_we;
  result_t              s1_result;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_id[0]             <= 29'd256;
      slave_id[1]             <= 29'd257;
      slave_id[2]             <= 29'd258;
      limits.crc_error_limit  <= 8'd3;
      limits.frame_loss_limit <= 8'd5;
      limits.credible_max     <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLAVE_ID_ZERO:    slave_id[0] <= cfg_data;
        CFG_SLAVE_ID_ONE:     slave_id[1] <= cfg_data;
        CFG_SLAVE_ID_TWO:     slave_id[2] <= cfg_data;
        CFG_CRC_ERROR_LIMIT:  limits.crc_error_limit <= cfg_data[7:0];
        CFG_FRAME_LOSS_LIMIT: limits.frame_loss_limit <= cfg_data[7:0];
        CFG_CREDIBLE_MAX:     limits.credible_max <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // slot lookup, lowest matching slot wins
  always_comb begin
    lookup_slot = NO_SLOT;
    lookup_hit  = 1'b0;
    for (int i = 0; i < NUM_SLAVES; i++) begin
      if (!lookup_hit && slave_id[i] == frame.can_id) begin
        lookup_hit  = 1'b1;
        lookup_slot = 2'(i);
      end
    end
    ram_raddr = lookup_hit ? lookup_slot[AW-1:0] : '0;
  end

  assign s1_go       = !result_valid || result_ready;
  assign s1_fire     = s1_valid && s1_go;
  assign frame_ready = !s1_valid || s1_go;
  assign frame_fire  = frame_valid && frame_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame_ready) begin
      s1_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_fire) begin
      s1_op      <= frame.op;
      s1_slot    <= lookup_slot;
      s1_seq     <= frame.seq_in;
      s1_payload <= frame.payload;
      s1_crc_ok  <= frame.crc_ok;
    end
  end

  cffm_ram #(
    .WIDTH (CTX_W),
    .DEPTH (NUM_SLAVES)
  ) u_ctx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_slot[AW-1:0]),
    .wdata (ctx_new),
    .re    (frame_fire),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // last write forwarded, unwritten entries read as zero
  assign fwd_hit = fwd_valid && (fwd_slot == s1_slot);

  always_comb begin
    if (fwd_hit) begin
      ctx_cur = fwd_ctx;
    end else if (s1_slot != NO_SLOT && ctx_valid[s1_slot[AW-1:0]]) begin
      ctx_cur = ram_q;
    end else begin
      ctx_cur = '0;
    end
  end

  assign {exp_seq, fail_count, fail_run, lost, muted, good_data} = ctx_cur;
  assign ctx_new = {exp_seq_next, fail_count_next, fail_run_next, lost_next,
                    muted_next, good_data_next};

  cffm_ctx_update #(
    .SEQ_BITS  (SEQ_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_update (
    .op              (s1_op),
    .slot            (s1_slot),
    .seq_in          (s1_seq),
    .payload         (s1_payload),
    .crc_ok          (s1_crc_ok),
    .limits          (limits),
    .exp_seq         (exp_seq),
    .fail_count      (fail_count),
    .fail_run        (fail_run),
    .lost            (lost),
    .muted           (muted),
    .good_data       (good_data),
    .ctx_wr          (ctx_wr),
    .exp_seq_next    (exp_seq_next),
    .fail_count_next (fail_count_next),
    .fail_run_next   (fail_run_next),
    .lost_next       (lost_next),
    .muted_next      (muted_next),
    .good_data_next  (good_data_next),
    .result          (s1_result)
  );

  assign ram_we = s1_fire && ctx_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_valid <= '0;
      fwd_valid <= 1'b0;
    end else if (s1_fire && s1_op == OP_CLEAR) begin
      ctx_valid <= '0;
      fwd_valid <= 1'b0;
    end else if (ram_we) begin
      ctx_valid[s1_slot[AW-1:0]] <= 1'b1;
      fwd_valid                  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_slot <= s1_slot;
      fwd_ctx  <= ctx_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result <= s1_result;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_no_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.slave_slot == NO_SLOT) |->
      (result.held_data == 16'd0 && result.crc_error_total == 16'd0))
    else $error("context fields reported without a matched slot");

  a_unknown_slot: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.result_code == RC_UNKNOWN) |->
      (result.slave_slot == NO_SLOT))
    else $error("unknown id with a matched slot");

  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (s1_slot != NO_SLOT && (s1_op == OP_CHECK || s1_op == OP_TX)))
    else $error("context write without a matched slot");

endmodule

`default_nettype wire

// ===== test/can_frame_fault_monitor_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// can_frame_fault_monitor_test
// Self-checking bench for the CAN frame fault monitor. A short table of frame
// and register requests comes first, some rows carrying their known result.
// Random traffic follows over several register settings, most of it in-order
// frames with bursts of CRC faults, gaps and clears mixed in. Every result is
// compared field by field against its known row result or a behavioral model
// of the slot contexts. Both sides idle in random bursts, except in the last
// part of the run.

module can_frame_fault_monitor_test;

  import cffm_pkg::*;

  localparam logic [1:0] OP_UNDEF  = 2'd3;
  localparam int PHASES            = 6;
  localparam int ITEMS_PER_PHASE   = 250;
  localparam int SINK_HOLD_CYCLES  = 200;
  localparam int SETTLE_CYCLES     = 8;
  localparam int DIRECTED_ROWS     = 30;

  typedef enum logic [1:0] {ROW_PREDICTED, ROW_TYPED, ROW_REG} row_kind_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [28:0] value;
  } reg_write_t;

  typedef struct packed {
    row_kind_t  kind;
    reg_write_t reg_write;
    frame_t     req;
    result_t    golden;
  } step_t;

  localparam step_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_TYPED, '0, '{OP_CHECK, 29'd256, 8'h00, 16'h1234, 1'b1},
      '{RC_OK, 2'd0, 8'd0, 16'h1234, 16'd0}},
    '{ROW_TYPED, '0, '{OP_TX, 29'd257, 8'h00, 16'h0000, 1'b0},
      '{RC_OK, 2'd1, 8'd0, 16'h0000, 16'd0}},
    '{ROW_TYPED, '0, '{OP_TX, 29'd257, 8'h00, 16'h0000, 1'b0},
      '{RC_OK, 2'd1, 8'd1, 16'h0000, 16'd0}},
    '{ROW_TYPED, '0, '{OP_CHECK, 29'd0, 8'hFF, 16'hFFFF, 1'b0},
      '{RC_UNKNOWN, NO_SLOT, 8'd0, 16'h0000, 16'd0}},
    '{ROW_TYPED, '0, '{OP_CHECK, 29'h1FFFFFFF, 8'h00, 16'h0000, 1'b1},
      '{RC_UNKNOWN, NO_SLOT, 8'd0, 16'h0000, 16'd0}},
    '{ROW_TYPED, '0, '{OP_TX, 29'h12345, 8'h00, 16'h0000, 1'b1},
      '{RC_UNKNOWN, NO_SLOT, 8'd0, 16'h0000, 16'd0}},
    '{ROW_TYPED, '0, '{OP_CHECK, 29'd258, 8'h00, 16'hFFFF, 1'b1},
      '{RC_OK, 2'd2, 8'd0, 16'hFFFF, 16'd0}},
    '{ROW_TYPED, '0, '{OP_CHECK, 29'd258, 8'h07, 16'h0005, 1'b1},
      '{RC_SYNC, 2'd2, 8'd0, 16'hFFFF, 16'd0}},
    '{ROW_TYPED, '0, '{OP_CHECK, 29'd258, 8'h08, 16'h0006, 1'b0},
      '{RC_CRC, 2'd2, 8'd0, 16'hFFFF, 16'd1}},
    '{ROW_TYPED, '0, '{OP_CHECK, 29'd258, 8'h08, 16'h0006, 1'b0},
      '{RC_CRC, 2'd2, 8'd0, 16'hFFFF, 16'd2}},
    '{ROW_TYPED, '0, '{OP_CHECK, 29'd258, 8'h08, 16'h0006, 1'b0},
      '{RC_CRC, 2'd2, 8'd0, 16'hFFFF, 16'd3}},
    '{ROW_TYPED, '0, '{OP_CHECK, 29'd258, 8'h00, 16'h0001, 1'b1},
      '{RC_MUTED, 2'd2, 8'd0, 16'hFFFF, 16'd3}},
    '{ROW_TYPED, '0, '{OP_TX, 29'd258, 8'h00, 16'h0000, 1'b1},
      '{RC_OK, 2'd2, 8'd0, 16'hFFFF, 16'd3}},
    '{ROW_TYPED, '0, '{OP_UNDEF, 29'd256, 8'hAA, 16'h5555, 1'b1},
      '{RC_OK, NO_SLOT, 8'd0, 16'h0000, 16'd0}},
    '{ROW_TYPED, '0, '{OP_CLEAR, 29'd258, 8'h00, 16'h0000, 1'b0},
      '{RC_OK, NO_SLOT, 8'd0, 16'h0000, 16'd0}},
    '{ROW_TYPED, '0, '{OP_CHECK, 29'd258, 8'h00, 16'h0001, 1'b1},
      '{RC_OK, 2'd2, 8'd0, 16'h0001, 16'd0}},
    '{ROW_TYPED, '0, '{OP_CHECK, 29'd256, 8'hFF, 16'h0002, 1'b1},
      '{RC_SYNC, 2'd0, 8'd0, 16'h0000, 16'd0}},
    '{ROW_PREDICTED, '0, '{OP_CHECK, 29'd256, 8'h00, 16'h00FF, 1'b1}, '0},
    '{ROW_PREDICTED, '0, '{OP_CHECK, 29'd257, 8'h80, 16'h0000, 1'b1}, '0},
    '{ROW_PREDICTED, '0, '{OP_CHECK, 29'd257, 8'h80, 16'h0000, 1'b1}, '0},
    '{ROW_PREDICTED, '0, '{OP_CHECK, 29'd257, 8'h80, 16'h0000, 1'b1}, '0},
    '{ROW_PREDICTED, '0, '{OP_CHECK, 29'd257, 8'h80, 16'h0000, 1'b1}, '0},
    '{ROW_PREDICTED, '0, '{OP_CHECK, 29'd257, 8'h80, 16'h0000, 1'b1}, '0},
    '{ROW_PREDICTED, '0, '{OP_CHECK, 29'd257, 8'h00, 16'h0003, 1'b1}, '0},
    '{ROW_REG, '{CFG_CREDIBLE_MAX, 29'h7FFF}, '0, '0},
    '{ROW_TYPED, '0, '{OP_CHECK, 29'd256, 8'h01, 16'h8000, 1'b1},
      '{RC_CREDIBILITY, 2'd0, 8'd0, 16'h00FF, 16'd0}},
    '{ROW_REG, '{CFG_SLAVE_ID_ONE, 29'd256}, '0, '0},
    '{ROW_PREDICTED, '0, '{OP_TX, 29'd256, 8'h00, 16'h0000, 1'b1}, '0},
    '{ROW_REG, '{CFG_CRC_ERROR_LIMIT, 29'd1}, '0, '0},
    '{ROW_PREDICTED, '0, '{OP_CHECK, 29'd256, 8'h02, 16'h0004, 1'b0}, '0}
  };

  logic        clk;
  logic        rst;
  logic        frame_valid;
  logic        frame_ready;
  frame_t      frame;
  logic        result_valid;
  logic        result_ready;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [28:0] cfg_data;

  // model of the registers and slot contexts
  logic [28:0] slave_ids    [SLOT_CAP];
  logic [7:0]  crc_limit;
  logic [7:0]  loss_limit;
  logic [15:0] max_credible;
  logic [7:0]  seq_next     [SLOT_CAP];
  logic [15:0] crc_total    [SLOT_CAP];
  logic [7:0]  crc_run      [SLOT_CAP];
  logic [7:0]  lost_frames  [SLOT_CAP];
  bit          muted        [SLOT_CAP];
  logic [15:0] held_value   [SLOT_CAP];

  result_t     expected_q [$];
  int unsigned frames_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned fault_count  = 0;
  int unsigned code_hits [8];
  bit          hold_sink    = 1'b0;
  bit          calm         = 1'b0;
  int          crc_burst    = 0;
  int          burst_slot   = 0;

  can_frame_fault_monitor dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame        (frame),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results still pending", expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void clear_contexts();
    for (int i = 0; i < SLOT_CAP; i++) begin
      seq_next[i]    = '0;
      crc_total[i]   = '0;
      crc_run[i]     = '0;
      lost_frames[i] = '0;
      muted[i]       = 1'b0;
      held_value[i]  = '0;
    end
  endfunction

  function automatic result_t predict_frame(input frame_t req);
    result_t res;
    int      slot;
    res = '0;
    res.result_code = RC_OK;
    res.slave_slot  = NO_SLOT;
    if (req.op == OP_CLEAR) begin
      clear_contexts();
    end else if (req.op == OP_CHECK || req.op == OP_TX) begin
      slot = SLOT_CAP;
      for (int i = SLOT_CAP - 1; i >= 0; i--) begin
        if (slave_ids[i] == req.can_id) slot = i;
      end
      if (slot == SLOT_CAP) begin
        res.result_code = RC_UNKNOWN;
      end else begin
        res.slave_slot = slot[1:0];
        if (req.op == OP_TX) begin
          res.tx_seq = seq_next[slot];
          seq_next[slot] = seq_next[slot] + 8'd1;
        end else if (muted[slot]) begin
          res.result_code = RC_MUTED;
        end else if (!req.crc_ok) begin
          if (crc_total[slot] != 16'hFFFF) crc_total[slot] = crc_total[slot] + 16'd1;
          if (crc_run[slot] != 8'hFF) crc_run[slot] = crc_run[slot] + 8'd1;
          if (crc_run[slot] >= crc_limit) begin
            muted[slot]       = 1'b1;
            lost_frames[slot] = '0;
            seq_next[slot]    = '0;
          end
          res.result_code = RC_CRC;
        end else begin
          crc_run[slot] = '0;
          if (req.payload > max_credible) begin
            res.result_code = RC_CREDIBILITY;
          end else if (req.seq_in != seq_next[slot]) begin
            if (lost_frames[slot] != 8'hFF) lost_frames[slot] = lost_frames[slot] + 8'd1;
            seq_next[slot] = req.seq_in + 8'd1;
            if (lost_frames[slot] >= loss_limit) begin
              lost_frames[slot] = '0;
              seq_next[slot]    = '0;
            end
            res.result_code = RC_SYNC;
          end else begin
            seq_next[slot]   = seq_next[slot] + 8'd1;
            held_value[slot] = req.payload;
          end
        end
        res.held_data       = held_value[slot];
        res.crc_error_total = crc_total[slot];
      end
    end
    return res;
  endfunction

  // mostly in-order frames for known slots, with crc fault bursts and noise
  function automatic frame_t random_frame();
    frame_t      req;
    int unsigned pick;
    int          k;
    int          hit;
    req.op      = OP_CHECK;
    req.can_id  = 29'($urandom);
    req.seq_in  = 8'($urandom);
    req.payload = 16'($urandom);
    req.crc_ok  = 1'($urandom);
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, SLOT_CAP - 1);
    if (crc_burst == 0 && pick < 3) begin
      crc_burst  = $urandom_range(1, 6);
      burst_slot = k;
    end
    if (crc_burst > 0) begin
      crc_burst--;
      req.can_id = slave_ids[burst_slot];
      req.crc_ok = 1'b0;
    end else if (pick < 72) begin
      req.can_id = slave_ids[k];
      hit = k;
      for (int i = SLOT_CAP - 1; i >= 0; i--) begin
        if (slave_ids[i] == req.can_id) hit = i;
      end
      req.seq_in  = seq_next[hit];
      req.payload = 16'($urandom_range(0, max_credible));
      req.crc_ok  = ($urandom_range(0, 24) != 0);
    end else if (pick < 82) begin
      req.op     = OP_TX;
      req.can_id = slave_ids[k];
    end else if (pick < 84) begin
      req.op = OP_CLEAR;
    end else if (pick < 86) begin
      req.op = OP_UNDEF;
    end else if (pick < 93) begin
      req.can_id = slave_ids[k];
    end else begin
      req.op = 2'($urandom);
    end
    return req;
  endfunction

  function automatic void log_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("%0t mismatch: %s", $time, what);
  endfunction

  function automatic void check_field(input string name, input int unsigned index,
                                      input logic [15:0] want, input logic [15:0] got);
    if (got !== want)
      log_fault($sformatf("result %0d %s expected %0h got %0h", index, name, want, got));
  endfunction

  task automatic send_frame(input frame_t req, input bit typed, input result_t golden);
    result_t model_out;
    if (!calm && frames_sent[6] && $urandom_range(0, 5) == 0) begin
      frame_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame       <= req;
    do @(posedge clk); while (!frame_ready);
    model_out = predict_frame(req);
    expected_q.push_back(typed ? golden : model_out);
    frames_sent++;
  endtask

  task automatic drain_results();
    frame_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  // leaves cfg_valid high; the caller lowers it after its last write
  task automatic write_reg(input logic [2:0] index, input logic [28:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_SLAVE_ID_ZERO:    slave_ids[0] = value;
      CFG_SLAVE_ID_ONE:     slave_ids[1] = value;
      CFG_SLAVE_ID_TWO:     slave_ids[2] = value;
      CFG_CRC_ERROR_LIMIT:  crc_limit    = value[7:0];
      CFG_FRAME_LOSS_LIMIT: loss_limit   = value[7:0];
      CFG_CREDIBLE_MAX:     max_credible = value[15:0];
      default: ;
    endcase
  endtask

  initial begin : result_sink
    int unsigned tick;
    tick = 0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_sink) begin
        result_ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
        result_ready <= 1'b1;
      end else if (!calm && tick[8] && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      code_hits[result.result_code]++;
      if (expected_q.size() == 0) begin
        log_fault($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = expected_q.pop_front();
        check_field("result_code", results_seen, want.result_code, result.result_code);
        check_field("slave_slot", results_seen, want.slave_slot, result.slave_slot);
        check_field("tx_seq", results_seen, want.tx_seq, result.tx_seq);
        check_field("held_data", results_seen, want.held_data, result.held_data);
        check_field("crc_error_total", results_seen, want.crc_error_total,
                    result.crc_error_total);
      end
    end
  end

  initial begin : stimulus
    logic [28:0] ids [SLOT_CAP];
    logic [7:0]  crc_lim;
    logic [7:0]  loss_lim;
    logic [15:0] data_lim;

    rst          <= 1'b1;
    frame_valid  <= 1'b0;
    frame        <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_SLAVE_ID_ZERO;
    cfg_data     <= '0;
    slave_ids    = '{29'd256, 29'd257, 29'd258};
    crc_limit    = 8'd3;
    loss_limit   = 8'd5;
    max_credible = 16'hFFFF;
    clear_contexts();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_REG) begin
        drain_results();
        write_reg(DIRECTED[r].reg_write.index, DIRECTED[r].reg_write.value);
        cfg_valid <= 1'b0;
      end else begin
        send_frame(DIRECTED[r].req, DIRECTED[r].kind == ROW_TYPED, DIRECTED[r].golden);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          ids = '{29'd256, 29'd257, 29'd258};
          crc_lim = 8'd3; loss_lim = 8'd5; data_lim = 16'hFFFF;
        end
        1: begin
          ids = '{29'd0, 29'h1FFFFFFF, 29'h0AAAAAAA};
          crc_lim = 8'd1; loss_lim = 8'd1; data_lim = 16'h0000;
        end
        2: begin
          ids = '{29'h123, 29'h123, 29'h123};
          crc_lim = 8'hFF; loss_lim = 8'hFF; data_lim = 16'hFFFF;
        end
        3: begin
          ids = '{29'($urandom), 29'($urandom), 29'($urandom)};
          crc_lim = 8'd0; loss_lim = 8'd0; data_lim = 16'($urandom);
        end
        4: begin
          ids = '{29'($urandom), 29'($urandom), 29'($urandom)};
          crc_lim  = 8'($urandom_range(1, 8));
          loss_lim = 8'($urandom_range(1, 8));
          data_lim = 16'($urandom);
        end
        default: begin
          ids = '{29'h1FFFFFFF, 29'h1FFFFFFE, 29'h15555555};
          crc_lim = 8'd2; loss_lim = 8'd3; data_lim = 16'h8000;
        end
      endcase
      drain_results();
      write_reg(CFG_SLAVE_ID_ZERO, ids[0]);
      write_reg(CFG_SLAVE_ID_ONE, ids[1]);
      write_reg(CFG_SLAVE_ID_TWO, ids[2]);
      write_reg(CFG_CRC_ERROR_LIMIT, 29'(crc_lim));
      write_reg(CFG_FRAME_LOSS_LIMIT, 29'(loss_lim));
      write_reg(CFG_CREDIBLE_MAX, 29'(data_lim));
      cfg_valid <= 1'b0;
      if (phase == PHASES - 1) calm = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long sink stall while requests keep coming
        if (phase == 2 && n == 20) hold_sink = 1'b1;
        if (phase == 4 && n == 125) drain_results();
        send_frame(random_frame(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_q.size() != 0)
      log_fault($sformatf("%0d results never arrived", expected_q.size()));

    $display("covered %0d requests: directed table and %0d register settings",
             frames_sent, PHASES);
    $display("results %0d: ok %0d unknown %0d muted %0d crc %0d not credible %0d resync %0d",
             results_seen, code_hits[RC_OK], code_hits[RC_UNKNOWN], code_hits[RC_MUTED],
             code_hits[RC_CRC], code_hits[RC_CREDIBILITY], code_hits[RC_SYNC]);
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fault_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
